// File: design/nsf_pkg.sv
// Shared constants, types and the sentence type check for the NMEA sentence filter.
`timescale 1ns / 1ps

package nsf_pkg;

  localparam int MAX_LEN   = 1024;
  localparam int LEN_W     = 11;
  localparam int HEAD_LEN  = 6;
  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = 3;
  localparam int QCNT_W    = 4;
  localparam int FLUSH_W   = 3;

  localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Accepted sentence types, three characters each, first character in the top byte.
  localparam int NUM_TYPES = 6;
  localparam logic [NUM_TYPES-1:0][23:0] TYPE_TABLE = {
    24'h565447,  // VTG
    24'h475341,  // GSA
    24'h475356,  // GSV
    24'h474C4C,  // GLL
    24'h474741,  // GGA
    24'h524D43   // RMC
  };

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_LAST,
    CMD_ABORT,
    CMD_FLUSH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic [7:0]                   data;
    logic [HEAD_LEN-1:0][7:0]     head;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic type_known(input logic [7:0] c3, input logic [7:0] c4,
                                      input logic [7:0] c5);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_TYPES; k++) begin
      if ({c3, c4, c5} == TYPE_TABLE[k]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: design/nsf_front.sv
// Front end: takes raw bytes, tracks the sentence and issues output commands.
`timescale 1ns / 1ps

module nsf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  nsf_pkg::queue_status_t q_status,
  output logic                 push,
  output nsf_pkg::cmd_t        cmd
);

  logic [nsf_pkg::LEN_W-1:0]      held_length;
  logic [nsf_pkg::LEN_W-1:0]      held_length_next;
  logic [nsf_pkg::HEAD_LEN-2:0][7:0] head;
  logic                           head_we;
  logic                           accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    held_length_next = held_length;
    head_we          = 1'b0;
    push             = 1'b0;
    cmd.kind         = nsf_pkg::CMD_BYTE;
    cmd.data         = in_byte;
    cmd.head         = {in_byte, head};
    if (accept) begin
      if (held_length == '0) begin
        if (in_byte == nsf_pkg::CHAR_DOLLAR) begin
          head_we          = 1'b1;
          held_length_next = nsf_pkg::LEN_W'(1);
        end
      end else if (in_byte == nsf_pkg::CHAR_NEWLINE &&
                   held_length > nsf_pkg::LEN_W'(nsf_pkg::HEAD_LEN)) begin
        push             = 1'b1;
        cmd.kind         = nsf_pkg::CMD_LAST;
        held_length_next = '0;
      end else if (held_length < nsf_pkg::LEN_W'(nsf_pkg::HEAD_LEN - 1)) begin
        head_we          = 1'b1;
        held_length_next = held_length + nsf_pkg::LEN_W'(1);
      end else if (held_length == nsf_pkg::LEN_W'(nsf_pkg::HEAD_LEN - 1)) begin
        // The sixth byte completes the type field: flush the head or drop the sentence.
        if (nsf_pkg::type_known(head[3], head[4], in_byte)) begin
          push             = 1'b1;
          cmd.kind         = nsf_pkg::CMD_FLUSH;
          held_length_next = nsf_pkg::LEN_W'(nsf_pkg::HEAD_LEN);
        end else begin
          held_length_next = '0;
        end
      end else if (held_length >= nsf_pkg::LEN_W'(nsf_pkg::MAX_LEN)) begin
        push             = 1'b1;
        cmd.kind         = nsf_pkg::CMD_ABORT;
        cmd.data         = '0;
        held_length_next = '0;
      end else begin
        push             = 1'b1;
        held_length_next = held_length + nsf_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_length <= '0;
    end else begin
      held_length <= held_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head[held_length[2:0]] <= in_byte;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    push |-> accept && held_length != '0)
    else $error("command issued without an accepted byte inside a sentence");

  assert property (@(posedge clk) disable iff (rst)
    held_length <= nsf_pkg::LEN_W'(nsf_pkg::MAX_LEN))
    else $error("held length exceeded the sentence limit");

  assert property (@(posedge clk) disable iff (rst)
    push && cmd.kind == nsf_pkg::CMD_FLUSH |=>
      held_length == nsf_pkg::LEN_W'(nsf_pkg::HEAD_LEN))
    else $error("head flush did not leave six bytes held");

endmodule

// File: design/nsf_queue.sv
// Short command queue between the front end and the output sequencer.
`timescale 1ns / 1ps

module nsf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  nsf_pkg::cmd_t          push_cmd,
  input  logic                   pop,
  output nsf_pkg::cmd_t          head_cmd,
  output nsf_pkg::queue_status_t status
);

  nsf_pkg::cmd_t                 entries [nsf_pkg::QDEPTH];
  logic [nsf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [nsf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [nsf_pkg::QCNT_W-1:0]    count;

  assign status.full  = (count == nsf_pkg::QCNT_W'(nsf_pkg::QDEPTH));
  assign status.empty = (count == '0);
  assign head_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + nsf_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + nsf_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + nsf_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - nsf_pkg::QCNT_W'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && status.full))
    else $error("push into a full queue");

  assert property (@(posedge clk) disable iff (rst) !(pop && status.empty))
    else $error("pop from an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    count <= nsf_pkg::QCNT_W'(nsf_pkg::QDEPTH))
    else $error("queue count out of range");

endmodule

// File: design/nsf_back.sv
// Output sequencer: expands queued commands into result transfers through an output register.
`timescale 1ns / 1ps

module nsf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  nsf_pkg::cmd_t          head_cmd,
  input  nsf_pkg::queue_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   last,
  output logic                   abort
);

  logic [nsf_pkg::FLUSH_W-1:0] flush_idx;
  logic                        load;

  // The output register loads whenever a command is queued and it is empty or being drained.
  assign load = !q_status.empty && (!out_valid || out_ready);
  assign pop  = load && (head_cmd.kind != nsf_pkg::CMD_FLUSH ||
                         flush_idx == nsf_pkg::FLUSH_W'(nsf_pkg::HEAD_LEN - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flush_idx <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && head_cmd.kind == nsf_pkg::CMD_FLUSH) begin
        if (pop) begin
          flush_idx <= '0;
        end else begin
          flush_idx <= flush_idx + nsf_pkg::FLUSH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      case (head_cmd.kind)
        nsf_pkg::CMD_FLUSH: begin
          out_byte <= head_cmd.head[flush_idx];
          last     <= 1'b0;
          abort    <= 1'b0;
        end
        nsf_pkg::CMD_LAST: begin
          out_byte <= head_cmd.data;
          last     <= 1'b1;
          abort    <= 1'b0;
        end
        nsf_pkg::CMD_ABORT: begin
          out_byte <= '0;
          last     <= 1'b0;
          abort    <= 1'b1;
        end
        default: begin
          out_byte <= head_cmd.data;
          last     <= 1'b0;
          abort    <= 1'b0;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    flush_idx != '0 |-> !q_status.empty && head_cmd.kind == nsf_pkg::CMD_FLUSH)
    else $error("flush in progress without a flush command at the queue head");

  assert property (@(posedge clk) disable iff (rst)
    flush_idx < nsf_pkg::FLUSH_W'(nsf_pkg::HEAD_LEN))
    else $error("flush index out of range");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(last && abort))
    else $error("result marked both last and abort");

endmodule

// File: design/nmea_sentence_filter.sv
// Top level of the NMEA sentence filter: front end, command queue and output sequencer.
// A passed byte, closing newline or abort is queued, then loaded into the output register.
// The six head bytes leave in order from the flush command that the sixth byte queues.
// Throughput: one input byte per cycle unless the queue is full; the output register sends
// one result per cycle unless out_ready is low, and the eight-entry queue absorbs the head flush.
// Reset (synchronous, active high) empties the queue and output register and returns to idle.
`timescale 1ns / 1ps

module nmea_sentence_filter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  output logic       abort
);

  nsf_pkg::queue_status_t q_status;
  nsf_pkg::cmd_t          push_cmd;
  nsf_pkg::cmd_t          head_cmd;
  logic                   push;
  logic                   pop;

  nsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_status (q_status),
    .push     (push),
    .cmd      (push_cmd)
  );

  nsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  nsf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .abort     (abort)
  );

endmodule
